### src/bdq_pkg.sv
package bdq_pkg;

    // queue geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = IDX_W + 1;
    localparam int SUM_W = PTR_W + 1;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int POS_W  = 4;
    localparam int FIX_W  = 4;
    localparam int OCC_W  = 5;

    // request operation codes
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_FIND       = 3'd2,
        OP_READ       = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_POP_BACK   = 3'd5
    } t_op;

    // response status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    // kind of result the controller asks the datapath to record
    typedef enum logic [2:0] {
        RES_OK,
        RES_EMPTY,
        RES_FULL,
        RES_MISS,
        RES_FOUND,
        RES_DATA
    } t_res;

    // read address source
    typedef enum logic [1:0] {
        RD_POS,
        RD_FIRST,
        RD_NEXT
    } t_rdsel;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] data_in;
        logic [POS_W-1:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic [FIX_W-1:0]         found_index;
        logic signed [DATA_W-1:0] data_out;
        logic [OCC_W-1:0]         occupancy;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic   latch_req;
        logic   push_front;
        logic   push_back;
        logic   pop_front;
        logic   pop_back;
        logic   rd_en;
        t_rdsel rd_sel;
        logic   idx_clr;
        logic   idx_inc;
        logic   set_res;
        t_res   res;
        logic   load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              pos_ok;
        logic              match;
        logic              last;
        logic              out_free;
    } t_sts;

endpackage

### src/bdq_ram.sv
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/bdq_ctrl.sv
module bdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bdq_pkg::t_sts i_sts,
    output bdq_pkg::t_cmd o_cmd
);
    import bdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.rd_sel = RD_POS;
        cmd.res    = RES_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.latch_req = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_DONE;
                cmd.set_res = 1'b1;
                unique case (i_sts.func)
                    OP_PUSH_FRONT: begin
                        if (i_sts.full) begin
                            cmd.res = RES_FULL;
                        end else begin
                            cmd.push_front = 1'b1;
                        end
                    end
                    OP_PUSH_BACK: begin
                        if (i_sts.full) begin
                            cmd.res = RES_FULL;
                        end else begin
                            cmd.push_back = 1'b1;
                        end
                    end
                    OP_FIND: begin
                        if (i_sts.empty) begin
                            cmd.res = RES_MISS;
                        end else begin
                            cmd.set_res = 1'b0;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = RD_FIRST;
                            cmd.idx_clr = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.pos_ok) begin
                            cmd.set_res = 1'b0;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = RD_POS;
                            n_state     = S_RDWAIT;
                        end else begin
                            cmd.res = RES_MISS;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (i_sts.empty) begin
                            cmd.res = RES_EMPTY;
                        end else begin
                            cmd.pop_front = 1'b1;
                        end
                    end
                    OP_POP_BACK: begin
                        if (i_sts.empty) begin
                            cmd.res = RES_EMPTY;
                        end else begin
                            cmd.pop_back = 1'b1;
                        end
                    end
                    default: begin
                        cmd.res = RES_OK;
                    end
                endcase
            end
            S_RDWAIT: begin
                cmd.set_res = 1'b1;
                cmd.res     = RES_DATA;
                n_state     = S_DONE;
            end
            S_SCAN: begin
                // compare the entry at the current index; with no match before the last, fetch the next one
                priority if (i_sts.match) begin
                    cmd.set_res = 1'b1;
                    cmd.res     = RES_FOUND;
                    n_state     = S_DONE;
                end else if (i_sts.last) begin
                    cmd.set_res = 1'b1;
                    cmd.res     = RES_MISS;
                    n_state     = S_DONE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cmd       = cmd;
endmodule

### src/bdq_dp.sv
module bdq_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bdq_pkg::t_req i_req,
    input  bdq_pkg::t_cmd i_cmd,
    output bdq_pkg::t_sts o_sts,
    input  logic          i_rsp_ready,
    output logic          o_rsp_valid,
    output bdq_pkg::t_rsp o_rsp
);
    import bdq_pkg::*;

    // ring slot of an offset from the front
    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] front,
                                                input logic [PTR_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    logic [IDX_W-1:0]  r_front;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [FUNC_W-1:0] r_func;
    logic [DATA_W-1:0] r_data_in;
    logic [POS_W-1:0]  r_pos;
    logic [1:0]        r_res_status;
    logic [FIX_W-1:0]  r_res_found;
    logic [DATA_W-1:0] r_res_data;
    t_rsp              r_out;

    logic [IDX_W-1:0]  front_dec;
    logic [IDX_W-1:0]  front_inc;
    logic [PTR_W-1:0]  idx_p1;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;
    logic              we;
    logic              out_free;

    // entry store
    bdq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_data_in),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // pointer arithmetic and addresses
    always_comb begin
        front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;
        front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        idx_p1    = PTR_W'(r_idx) + 1'b1;
        we        = i_cmd.push_front | i_cmd.push_back;
        waddr     = i_cmd.push_front ? front_dec : f_slot(r_front, PTR_W'(r_count));
        unique case (i_cmd.rd_sel)
            RD_POS:   raddr = f_slot(r_front, PTR_W'(r_pos));
            RD_FIRST: raddr = f_slot(r_front, '0);
            RD_NEXT:  raddr = f_slot(r_front, idx_p1);
            default:  raddr = r_front;
        endcase
    end

    // status to the controller
    assign out_free     = !r_out_valid || i_rsp_ready;
    assign o_sts.func   = r_func;
    assign o_sts.full   = (r_count == CNT_W'(DEPTH));
    assign o_sts.empty  = (r_count == '0);
    assign o_sts.pos_ok = (32'(r_pos) < 32'(r_count));
    assign o_sts.match  = (rdata == r_data_in);
    assign o_sts.last   = (idx_p1 == PTR_W'(r_count));
    assign o_sts.out_free = out_free;

    // front pointer, count, scan index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push_front) begin
                r_front <= front_dec;
            end else if (i_cmd.pop_front) begin
                r_front <= front_inc;
            end
            if (i_cmd.push_front || i_cmd.push_back) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop_front || i_cmd.pop_back) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, result and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_func    <= i_req.func;
            r_data_in <= i_req.data_in;
            r_pos     <= i_req.position;
        end
        if (i_cmd.set_res) begin
            unique case (i_cmd.res)
                RES_EMPTY: r_res_status <= ST_EMPTY;
                RES_FULL:  r_res_status <= ST_FULL;
                RES_MISS:  r_res_status <= ST_MISS;
                default:   r_res_status <= ST_OK;
            endcase
            r_res_found <= (i_cmd.res == RES_FOUND) ? FIX_W'(r_idx) : '0;
            r_res_data  <= (i_cmd.res == RES_DATA) ? rdata : '0;
        end
        if (i_cmd.load_out) begin
            r_out.status      <= r_res_status;
            r_out.found_index <= r_res_found;
            r_out.data_out    <= r_res_data;
            r_out.occupancy   <= OCC_W'(r_count);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
endmodule

### src/bounded_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit words kept as a ring in a
// single-port-read RAM of DEPTH entries. One request is taken at a time and
// gives exactly one response with status, found index, read data and the
// occupancy after the request. Pushes, pops, unused codes, out-of-range reads
// and finds on an empty queue go from the execute state straight to the done
// state, a read at an index inside the count waits in the read-wait state for
// the RAM data, and any other find scans until a match or the last entry;
// the find walks the ring one entry per cycle through the RAM's
// registered read port. The response sits in an output register, and a new
// request is taken while it waits; a further response is held until that one
// is transferred.
module bounded_deque_with_search (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bdq_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output bdq_pkg::t_rsp o_rsp
);
    import bdq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // pointers, store and response register
    bdq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );
endmodule

### src/bdq_checker.sv
module bdq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_ready,
    input logic          o_rsp_valid,
    input logic          i_rsp_ready,
    input bdq_pkg::t_rsp o_rsp
);
    import bdq_pkg::*;

    // one request at a time, ready drops after a transfer
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request ready held after a transfer");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // a refused push only happens on a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_FULL) |-> o_rsp.occupancy == OCC_W'(DEPTH))
        else $error("full status with queue not full");

    // an empty status only on an empty queue
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_EMPTY) |-> o_rsp.occupancy == '0)
        else $error("empty status with entries held");

    // index and data only come with a good status
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && ((o_rsp.found_index != '0) || (o_rsp.data_out != '0))
        |-> o_rsp.status == ST_OK)
        else $error("index or data with failing status");
endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

### sim/deque_checker.sv
`timescale 1ns / 1ps

module deque_checker
    import bdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    // shadow copy of the ring and its pointers
    logic signed [DATA_W-1:0] word_ring [DEPTH];
    logic [IDX_W-1:0]         head_slot;
    logic [CNT_W-1:0]         fill_level;

    // responses predicted but not yet seen
    t_rsp pending_rsp [$];
    int   fail_count;

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        head_slot    = '0;
        fill_level   = '0;
    end

    function automatic logic [IDX_W-1:0] slot_at(input int offset);
        return IDX_W'((head_slot + offset) % DEPTH);
    endfunction

    // apply one request to the shadow queue and build its response
    task automatic apply_request(input t_req r, output t_rsp res);
        res = '0;
        res.status = ST_OK;
        case (r.func)
            OP_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    head_slot = IDX_W'((head_slot + DEPTH - 1) % DEPTH);
                    word_ring[head_slot] = r.data_in;
                    fill_level++;
                end
            end
            OP_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    word_ring[slot_at(int'(fill_level))] = r.data_in;
                    fill_level++;
                end
            end
            OP_FIND: begin
                res.status = ST_MISS;
                for (int at = 0; at < fill_level; at++) begin
                    if (word_ring[slot_at(at)] == r.data_in) begin
                        res.status      = ST_OK;
                        res.found_index = at[FIX_W-1:0];
                        break;
                    end
                end
            end
            OP_READ: begin
                if (r.position < fill_level) begin
                    res.data_out = word_ring[slot_at(int'(r.position))];
                end else begin
                    res.status = ST_MISS;
                end
            end
            OP_POP_FRONT: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    head_slot = slot_at(1);
                    fill_level--;
                end
            end
            OP_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    fill_level--;
                end
            end
            default: ;
        endcase
        res.occupancy = fill_level[OCC_W-1:0];
    endtask

    // watch both channels, compare responses, predict requests
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            head_slot  = '0;
            fill_level = '0;
            pending_rsp.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $write("checker: unexpected response status %0d index %0d ",
                               i_rsp.status, i_rsp.found_index);
                        $display("data %0d occ %0d", i_rsp.data_out, i_rsp.occupancy);
                    end
                end else begin
                    want = pending_rsp.pop_front();
                    if (want !== i_rsp) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $write("checker: mismatch, expected status %0d index %0d ",
                                   want.status, want.found_index);
                            $write("data %0d occ %0d, ", want.data_out, want.occupancy);
                            $display("got status %0d index %0d data %0d occ %0d",
                                     i_rsp.status, i_rsp.found_index, i_rsp.data_out,
                                     i_rsp.occupancy);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req, want);
                pending_rsp.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_rsp.size();
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bdq_pkg::*;

    // func codes outside the operation set, the block ignores them
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_START   = 2500;
    localparam int HOLD_CYCLES  = 400;

    logic i_clk     = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    t_req req       = '0;
    logic rsp_ready = 1'b0;
    logic hold_rsp  = 1'b0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int rsp_idle    = 0;
    int rsp_seen    = 0;
    bit quiet_rsp   = 1'b0;

    always #5 i_clk = ~i_clk;

    bounded_deque_with_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (o_rsp)
    );

    deque_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // response side: random wait before each transfer, quiet stretches
    always @(posedge i_clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            rsp_idle  <= $urandom_range(0, 10);
        end else if (rsp_ready && o_rsp_valid) begin
            rsp_seen <= rsp_seen + 1;
            if ((rsp_seen % 150) == 149)
                quiet_rsp <= $urandom_range(0, 2) == 0;
            if (quiet_rsp && !hold_rsp) begin
                rsp_ready <= 1'b1;
            end else begin
                rsp_ready <= 1'b0;
                rsp_idle  <= $urandom_range(0, 10);
            end
        end else if (hold_rsp) begin
            rsp_ready <= 1'b0;
        end else if (!rsp_ready) begin
            if (rsp_idle == 0)
                rsp_ready <= 1'b1;
            else
                rsp_idle <= rsp_idle - 1;
        end
    end

    // one long response stall so the block backs up into the request side
    initial begin
        wait (rst_n);
        repeat (HOLD_START) @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    // offer one request after a random gap and wait for its transfer
    task automatic send(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] d,
                        input logic [POS_W-1:0] p, input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req       <= '{func: f, data_in: d, position: p};
        do @(posedge i_clk); while (!(req_valid && o_req_ready));
    endtask

    initial begin
        logic signed [DATA_W-1:0] pool [8];
        logic signed [DATA_W-1:0] word;
        logic [FUNC_W-1:0]        func;
        int push_w, pop_w, pick, gap_max, mode;

        // small value set so finds hit and duplicates appear
        pool[0] = 32'sh7fffffff;
        pool[1] = 32'sh80000000;
        pool[2] = 32'sh00000000;
        pool[3] = 32'shffffffff;
        pool[4] = 32'sh00000001;
        for (int n = 5; n < 8; n++)
            pool[n] = $urandom;

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // empty queue corners and ignored codes
        send(OP_POP_FRONT, '0, '0, 10);
        send(OP_POP_BACK, '1, '1, 10);
        send(OP_FIND, '0, '0, 10);
        send(OP_READ, '0, '0, 10);
        send(FUNC_SPARE_LO, '1, '1, 10);
        send(FUNC_SPARE_HI, '0, '0, 10);

        // fill from both ends with extreme values first
        for (int n = 0; n < DEPTH; n++) begin
            word = (n < 4) ? pool[n] : $urandom;
            send(n[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, word, n[POS_W-1:0], 0);
        end

        // full queue: refused push, last index read, deepest find
        send(OP_PUSH_BACK, pool[4], '0, 10);
        send(OP_READ, '0, 4'd15, 10);
        send(OP_FIND, word, '0, 10);

        // random part cycling through fill, drain and balanced phases
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            mode    = (k / 64) % 3;
            gap_max = ((k / 150) % 3 == 0) ? 0 : 10;
            push_w  = (mode == 0) ? 60 : (mode == 1) ? 15 : 30;
            pop_w   = (mode == 0) ? 8 : (mode == 1) ? 53 : 28;
            pick    = $urandom_range(0, 99);
            if (pick < push_w) begin
                func = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                word = $urandom_range(0, 1) ? pool[3'($urandom_range(0, 7))] : $urandom;
            end else if (pick < push_w + pop_w) begin
                func = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                word = $urandom;
            end else if (pick < push_w + pop_w + 2) begin
                func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
                word = $urandom;
            end else begin
                func = $urandom_range(0, 1) ? OP_READ : OP_FIND;
                word = ($urandom_range(0, 9) < 7) ? pool[3'($urandom_range(0, 7))]
                                                  : $urandom;
            end
            send(func, word, POS_W'($urandom_range(0, 15)), gap_max);
        end
        req_valid <= 1'b0;

        // drain outstanding responses
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
